/* src/ctl_pkg.sv */
package ctl_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned TUPLE_WORDS_DEF = 3;
  localparam int unsigned MAX_WORDS       = 5;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned FUNC_W          = 4;
  localparam int unsigned LEN_W           = 7;
  localparam int unsigned CUR_W           = 6;
  localparam int unsigned IDX_MAX_W       = 9;
  localparam int unsigned IN_DATA_W       = 168;
  localparam int unsigned OUT_DATA_W      = 176;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT    = 4'd0,
    FN_REMOVE    = 4'd1,
    FN_SWAP_FWD  = 4'd2,
    FN_SWAP_BACK = 4'd3,
    FN_CUR_FWD   = 4'd4,
    FN_CUR_BACK  = 4'd5,
    FN_GET       = 4'd6,
    FN_SET       = 4'd7,
    FN_CONTAINS  = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_UP,
    SH_DOWN,
    SH_SWAP
  } shift_e;

  typedef struct packed {
    shift_e               mode;
    logic [IDX_MAX_W-1:0] lo;
    logic [IDX_MAX_W-1:0] hi;
    logic                 load;
    logic [IDX_MAX_W-1:0] load_idx;
    logic [IDX_MAX_W-1:0] len;
  } cell_ctrl_t;

endpackage

/* src/ctl_cell.sv */
module ctl_cell #(
  parameter int unsigned K           = 0,
  parameter int unsigned TUPLE_WORDS = ctl_pkg::TUPLE_WORDS_DEF
) (
  input  logic                                        clk_i,
  input  ctl_pkg::cell_ctrl_t                         ctrl_i,
  input  logic [TUPLE_WORDS-1:0][ctl_pkg::WORD_W-1:0] key_i,
  input  logic [TUPLE_WORDS-1:0][ctl_pkg::WORD_W-1:0] prev_i,
  input  logic [TUPLE_WORDS-1:0][ctl_pkg::WORD_W-1:0] next_i,
  output logic [TUPLE_WORDS-1:0][ctl_pkg::WORD_W-1:0] data_o,
  output logic                                        match_o
);
  import ctl_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MyIdx = IDX_MAX_W'(K);

  logic [TUPLE_WORDS-1:0][WORD_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.mode)
      SH_UP: begin
        if (MyIdx > ctrl_i.lo && MyIdx <= ctrl_i.hi) data_d = prev_i;
      end
      SH_DOWN: begin
        if (MyIdx >= ctrl_i.lo && MyIdx < ctrl_i.hi) data_d = next_i;
      end
      SH_SWAP: begin
        if (MyIdx == ctrl_i.lo) begin
          data_d = next_i;
        end else if (MyIdx == ctrl_i.lo + 1'b1) begin
          data_d = prev_i;
        end
      end
      default: ;
    endcase
    if (ctrl_i.load && MyIdx == ctrl_i.load_idx) data_d = key_i;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (MyIdx < ctrl_i.len) && (data_q == key_i);

endmodule

/* src/cursor_tuple_list.sv */
// Bounded ordered list of DEPTH tuples (TUPLE_WORDS 32-bit words each) with a
// cursor. Every input transfer gives exactly one output transfer carrying the
// status, length and cursor after the operation, the contains flag and, for
// get, the tuple at the cursor. The tuples sit in a row of cells that shift
// toward or away from their neighbors, so insert and remove move the whole
// tail at once and contains compares every cell at once. An item is first
// registered in the command register, then executed in the cell row while
// its result loads the output register; the next item is taken only once the
// command register is free, and execution waits while the output side is
// stalled. The stored tuples have no reset; length and cursor reset to zero.
module cursor_tuple_list #(
  parameter int unsigned DEPTH       = ctl_pkg::DEPTH_DEF,
  parameter int unsigned TUPLE_WORDS = ctl_pkg::TUPLE_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // func[3:0], value_0..value_4 (32 bits each) from bit 4 up, zero pad
  input  logic [ctl_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status[0], length[7:1], cursor[13:8], found[14], out_0..out_4 from bit 15 up
  output logic [ctl_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);
  import ctl_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IW    = $clog2(DEPTH);

  typedef logic [TUPLE_WORDS-1:0][WORD_W-1:0] tuple_t;

  logic                          cmd_vld_q, cmd_vld_d;
  logic [FUNC_W-1:0]             cmd_func_q;
  tuple_t                        cmd_key_q;
  logic [CNT_W-1:0]              len_q, len_d;
  logic [IW-1:0]                 cur_q, cur_d;
  logic                          m_vld_q, m_vld_d;
  logic                          res_status_q, res_status_d;
  logic                          res_found_q, res_found_d;
  logic [LEN_W-1:0]              res_len_q;
  logic [CUR_W-1:0]              res_cur_q;
  logic [MAX_WORDS-1:0][WORD_W-1:0] res_word_q, res_word_d;

  logic                          accept, exec;
  logic [CNT_W-1:0]              cur_ext, cur_p1, ins_pos;
  logic                          cur_in_list;
  cell_ctrl_t                    ctrl;
  tuple_t                        cell_data [DEPTH];
  logic [DEPTH-1:0]              match;

  assign s_axis_tready_o = !cmd_vld_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign exec            = cmd_vld_q && (!m_vld_q || m_axis_tready_i);

  assign cur_ext     = CNT_W'(cur_q);
  assign cur_p1      = cur_ext + 1'b1;
  assign cur_in_list = cur_ext < len_q;
  assign ins_pos     = (len_q == '0) ? '0 : (!cur_in_list ? len_q : cur_p1);

  always_comb begin
    cmd_vld_d = cmd_vld_q;
    if (accept) begin
      cmd_vld_d = 1'b1;
    end else if (exec) begin
      cmd_vld_d = 1'b0;
    end
  end

  always_comb begin
    len_d         = len_q;
    cur_d         = cur_q;
    res_status_d  = 1'b0;
    res_found_d   = 1'b0;
    res_word_d    = '0;
    ctrl          = '0;
    ctrl.mode     = SH_NONE;
    ctrl.len      = IDX_MAX_W'(len_q);
    if (exec) begin
      unique case (func_e'(cmd_func_q))
        FN_INSERT: begin
          if (len_q == CNT_W'(DEPTH)) begin
            res_status_d = 1'b1;
          end else begin
            ctrl.mode     = SH_UP;
            ctrl.lo       = IDX_MAX_W'(ins_pos);
            ctrl.hi       = IDX_MAX_W'(len_q);
            ctrl.load     = 1'b1;
            ctrl.load_idx = IDX_MAX_W'(ins_pos);
            len_d         = len_q + 1'b1;
          end
        end
        FN_REMOVE: begin
          if (!cur_in_list) begin
            res_status_d = 1'b1;
          end else begin
            ctrl.mode = SH_DOWN;
            ctrl.lo   = IDX_MAX_W'(cur_q);
            ctrl.hi   = IDX_MAX_W'(len_q - 1'b1);
            len_d     = len_q - 1'b1;
          end
        end
        FN_SWAP_FWD: begin
          if (cur_p1 >= len_q) begin
            res_status_d = 1'b1;
          end else begin
            ctrl.mode = SH_SWAP;
            ctrl.lo   = IDX_MAX_W'(cur_q);
          end
        end
        FN_SWAP_BACK: begin
          if (cur_q == '0 || !cur_in_list) begin
            res_status_d = 1'b1;
          end else begin
            ctrl.mode = SH_SWAP;
            ctrl.lo   = IDX_MAX_W'(cur_q - 1'b1);
          end
        end
        FN_CUR_FWD: begin
          if (cur_p1 >= len_q) begin
            res_status_d = 1'b1;
          end else begin
            cur_d = cur_q + 1'b1;
          end
        end
        FN_CUR_BACK: begin
          if (cur_q == '0) begin
            res_status_d = 1'b1;
          end else begin
            cur_d = cur_q - 1'b1;
          end
        end
        FN_GET: begin
          if (!cur_in_list) begin
            res_status_d = 1'b1;
          end else begin
            for (int w = 0; w < TUPLE_WORDS; w++) begin
              res_word_d[w] = cell_data[cur_q][w];
            end
          end
        end
        FN_SET: begin
          if (!cur_in_list) begin
            res_status_d = 1'b1;
          end else begin
            ctrl.load     = 1'b1;
            ctrl.load_idx = IDX_MAX_W'(cur_q);
          end
        end
        FN_CONTAINS: begin
          res_found_d = |match;
        end
        default: begin
          res_status_d = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (exec) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    tuple_t prev_data, next_data;
    if (k == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid
      assign prev_data = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_body
      assign next_data = cell_data[k+1];
    end
    ctl_cell #(
      .K           (k),
      .TUPLE_WORDS (TUPLE_WORDS)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .key_i   (cmd_key_q),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[k]),
      .match_o (match[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      len_q     <= '0;
      cur_q     <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
      len_q     <= len_d;
      cur_q     <= cur_d;
      m_vld_q   <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_func_q <= s_axis_tdata_i[FUNC_W-1:0];
      for (int w = 0; w < TUPLE_WORDS; w++) begin
        cmd_key_q[w] <= s_axis_tdata_i[FUNC_W + WORD_W*w +: WORD_W];
      end
    end
    if (exec) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_len_q    <= LEN_W'(len_d);
      res_cur_q    <= CUR_W'(cur_d);
      res_word_q   <= res_word_d;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {1'b0, res_word_q, res_found_q, res_cur_q, res_len_q, res_status_q};

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(DEPTH))
    else $error("list length beyond depth");

  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_ext <= len_q)
    else $error("cursor beyond length");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != $past(len_q) |-> (len_q == $past(len_q) + 1'b1 || len_q == $past(len_q) - 1'b1))
    else $error("length changed by more than one");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> (len_q == $past(len_q) && cur_q == $past(cur_q)))
    else $error("length or cursor changed without a command");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> m_vld_q && !cmd_vld_q)
    else $error("executed command gave no result");

endmodule
